// ===== design/rsps_pkg.sv =====
// ----------------------------------------------------------------------------
// rsps_pkg
// Shared types and constants for the range-sum and pair-sum search block.
// ----------------------------------------------------------------------------
package rsps_pkg;

    // Data set sizing
    localparam int CAPACITY   = 8;
    localparam int ELEM_WIDTH = 32;

    // Fixed field widths of the ports
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int FIELD_W     = 32;
    localparam int RANGE_IDX_W = 3;
    localparam int RANGE_SUM_W = 35;

    // Derived widths
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int PSUM_W = ELEM_WIDTH + IDX_W;
    localparam int DIFF_W = PSUM_W + 1;
    localparam int QW     = (CNT_W > RANGE_IDX_W) ? CNT_W : RANGE_IDX_W;
    localparam int SUM_EXT_W = (DIFF_W > RANGE_SUM_W) ? DIFF_W : RANGE_SUM_W;
    // pair sums are compared against a 32-bit target
    localparam int CMP_W  = FIELD_W + 1;

    // Saturation bounds of the range sum field, at the extended width
    localparam logic signed [SUM_EXT_W-1:0] SUM_MAX =
        SUM_EXT_W'($signed({1'b0, {(RANGE_SUM_W-1){1'b1}}}));
    localparam logic signed [SUM_EXT_W-1:0] SUM_MIN =
        SUM_EXT_W'($signed({1'b1, {(RANGE_SUM_W-1){1'b0}}}));

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_RANGE  = 2'd2,
        CMD_PAIR   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_RANGE = 2'd1,
        ST_NO_PAIR   = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_RANGE,
        S_PAIR,
        S_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic clear;
        logic append_start;
        logic ins_step;
        logic range_start;
        logic range_finish;
        logic pair_start;
        logic pair_step;
        logic res_full;
        logic res_bad_range;
        logic res_no_pair;
        logic out_load;
    } ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic range_bad;
        logic few;
        logic ins_done;
        logic pair_hit;
        logic pair_end;
    } flags_t;

endpackage

// ===== design/rsps_ram.sv =====
// ----------------------------------------------------------------------------
// rsps_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rsps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr0,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr1,
    output logic [WIDTH-1:0]                        rdata0,
    output logic [WIDTH-1:0]                        rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// ===== design/rsps_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsps_ctrl
// Sequencer: decodes a beat, steps the insert / range / pair phases and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module rsps_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [rsps_pkg::CMD_W-1:0] s_command,
    output logic                       m_valid,
    input  logic                       m_ready,
    input  rsps_pkg::flags_t           flags,
    output rsps_pkg::ctl_t             ctl
);

    rsps_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    // State and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rsps_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == rsps_pkg::S_IDLE);
    assign m_valid  = m_valid_reg;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        ctl          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            rsps_pkg::S_IDLE: begin
                if (s_valid) begin
                    ctl.capture = 1'b1;
                    state_next  = rsps_pkg::S_DONE;
                    unique case (rsps_pkg::cmd_t'(s_command))
                        rsps_pkg::CMD_CLEAR: begin
                            ctl.clear = 1'b1;
                        end
                        rsps_pkg::CMD_APPEND: begin
                            if (flags.full) begin
                                ctl.res_full = 1'b1;
                            end else begin
                                ctl.append_start = 1'b1;
                                state_next       = rsps_pkg::S_INSERT;
                            end
                        end
                        rsps_pkg::CMD_RANGE: begin
                            if (flags.range_bad) begin
                                ctl.res_bad_range = 1'b1;
                            end else begin
                                ctl.range_start = 1'b1;
                                state_next      = rsps_pkg::S_RANGE;
                            end
                        end
                        rsps_pkg::CMD_PAIR: begin
                            if (flags.few) begin
                                ctl.res_no_pair = 1'b1;
                            end else begin
                                ctl.pair_start = 1'b1;
                                state_next     = rsps_pkg::S_PAIR;
                            end
                        end
                        default: begin
                            ctl.clear = 1'b1;
                        end
                    endcase
                end
            end
            rsps_pkg::S_INSERT: begin
                ctl.ins_step = 1'b1;
                if (flags.ins_done) begin
                    state_next = rsps_pkg::S_DONE;
                end
            end
            rsps_pkg::S_RANGE: begin
                ctl.range_finish = 1'b1;
                state_next       = rsps_pkg::S_DONE;
            end
            rsps_pkg::S_PAIR: begin
                ctl.pair_step = 1'b1;
                if (flags.pair_hit || flags.pair_end) begin
                    state_next = rsps_pkg::S_DONE;
                end
            end
            rsps_pkg::S_DONE: begin
                if (out_free) begin
                    ctl.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = rsps_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rsps_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/rsps_datapath.sv =====
// ----------------------------------------------------------------------------
// rsps_datapath
// Element count, running prefix sum, prefix and sorted stores, insertion
// and two-pointer walk, result and output registers.
// ----------------------------------------------------------------------------
module rsps_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rsps_pkg::ctl_t                        ctl,
    output rsps_pkg::flags_t                      flags,
    input  logic signed [rsps_pkg::FIELD_W-1:0]   s_value,
    input  logic [rsps_pkg::RANGE_IDX_W-1:0]      s_range_left,
    input  logic [rsps_pkg::RANGE_IDX_W-1:0]      s_range_right,
    input  logic signed [rsps_pkg::FIELD_W-1:0]   s_target,
    output logic [rsps_pkg::STATUS_W-1:0]         m_status,
    output logic signed [rsps_pkg::RANGE_SUM_W-1:0] m_range_sum,
    output logic signed [rsps_pkg::FIELD_W-1:0]   m_pair_low,
    output logic signed [rsps_pkg::FIELD_W-1:0]   m_pair_high
);

    localparam int EW = rsps_pkg::ELEM_WIDTH;
    localparam int IW = rsps_pkg::IDX_W;
    localparam int CW = rsps_pkg::CNT_W;
    localparam int PW = rsps_pkg::PSUM_W;
    localparam int QW = rsps_pkg::QW;
    localparam int FW = rsps_pkg::FIELD_W;
    localparam int XW = rsps_pkg::SUM_EXT_W;
    localparam int MW = rsps_pkg::CMP_W;
    localparam int RW = rsps_pkg::RANGE_SUM_W;

    // Control-side state
    logic [CW-1:0]          count_reg, count_next;
    // Payload registers
    logic signed [PW-1:0]   last_reg, last_next;
    logic [IW-1:0]          pos_reg, pos_next;
    logic [IW-1:0]          a_reg, a_next;
    logic [IW-1:0]          b_reg, b_next;
    logic signed [EW-1:0]   value_reg;
    logic signed [FW-1:0]   target_reg;
    logic                   lzero_reg;
    rsps_pkg::status_t      res_status_reg, res_status_next;
    logic signed [RW-1:0]   res_sum_reg, res_sum_next;
    logic signed [FW-1:0]   res_lo_reg, res_lo_next;
    logic signed [FW-1:0]   res_hi_reg, res_hi_next;
    logic [rsps_pkg::STATUS_W-1:0] out_status_reg;
    logic signed [RW-1:0]   out_sum_reg;
    logic signed [FW-1:0]   out_lo_reg;
    logic signed [FW-1:0]   out_hi_reg;

    // Store ports
    logic                   pfx_we;
    logic [IW-1:0]          pfx_waddr, pfx_raddr0, pfx_raddr1;
    logic [PW-1:0]          pfx_wdata, pfx_rdata0, pfx_rdata1;
    logic                   srt_we;
    logic [IW-1:0]          srt_waddr, srt_raddr0, srt_raddr1;
    logic [EW-1:0]          srt_wdata, srt_rdata0, srt_rdata1;

    // Helper values
    logic signed [EW-1:0]   in_elem;
    logic signed [EW-1:0]   rd_a, rd_b;
    logic [CW-1:0]          count_m1;
    logic [QW-1:0]          l_q, r_q, cnt_q, l_m1;
    logic signed [PW:0]     diff;
    logic signed [XW-1:0]   diff_ext;
    logic signed [RW-1:0]   sum_sat;
    logic signed [MW-1:0]   pair_sum, pair_tgt;
    logic                   pair_lt;
    logic [IW-1:0]          step_a, step_b;

    assign in_elem  = s_value[EW-1:0];
    assign rd_a     = srt_rdata0;
    assign rd_b     = srt_rdata1;
    assign count_m1 = count_reg - CW'(1);
    assign l_q      = QW'(s_range_left);
    assign r_q      = QW'(s_range_right);
    assign cnt_q    = QW'(count_reg);
    assign l_m1     = l_q - QW'(1);

    // Status flags for the sequencer
    assign flags.full      = (count_reg == CW'(rsps_pkg::CAPACITY));
    assign flags.range_bad = (r_q >= cnt_q) || (l_q > r_q);
    assign flags.few       = (count_reg < CW'(2));
    assign flags.ins_done  = (pos_reg == '0) || !(rd_a > value_reg);

    // Range sum: difference of two prefix entries, saturated to the field
    assign diff     = $signed({pfx_rdata1[PW-1], pfx_rdata1})
                    - (lzero_reg ? '0 : $signed({pfx_rdata0[PW-1], pfx_rdata0}));
    assign diff_ext = XW'(diff);
    always_comb begin
        if (diff_ext > rsps_pkg::SUM_MAX) begin
            sum_sat = rsps_pkg::SUM_MAX[RW-1:0];
        end else if (diff_ext < rsps_pkg::SUM_MIN) begin
            sum_sat = rsps_pkg::SUM_MIN[RW-1:0];
        end else begin
            sum_sat = diff_ext[RW-1:0];
        end
    end

    // Two-pointer compare, exact width
    assign pair_sum = MW'(rd_a) + MW'(rd_b);
    assign pair_tgt = MW'(target_reg);
    assign pair_lt  = pair_sum < pair_tgt;
    assign step_a   = pair_lt ? a_reg + IW'(1) : a_reg;
    assign step_b   = pair_lt ? b_reg : b_reg - IW'(1);
    assign flags.pair_hit = (pair_sum == pair_tgt);
    assign flags.pair_end = (step_a >= step_b);

    // Next-state logic for counters, pointers and result
    always_comb begin
        count_next      = count_reg;
        last_next       = last_reg;
        pos_next        = pos_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        res_status_next = res_status_reg;
        res_sum_next    = res_sum_reg;
        res_lo_next     = res_lo_reg;
        res_hi_next     = res_hi_reg;
        pfx_we          = 1'b0;
        pfx_waddr       = count_reg[IW-1:0];
        pfx_wdata       = last_reg + PW'(in_elem);
        srt_we          = 1'b0;
        srt_waddr       = pos_reg;
        srt_wdata       = rd_a;

        if (ctl.capture) begin
            res_status_next = rsps_pkg::ST_OK;
            res_sum_next    = '0;
            res_lo_next     = '0;
            res_hi_next     = '0;
        end
        if (ctl.clear) begin
            count_next = '0;
            last_next  = '0;
        end
        if (ctl.res_full) begin
            res_status_next = rsps_pkg::ST_FULL;
        end
        if (ctl.res_bad_range) begin
            res_status_next = rsps_pkg::ST_BAD_RANGE;
        end
        if (ctl.res_no_pair) begin
            res_status_next = rsps_pkg::ST_NO_PAIR;
        end
        // append: extend prefix store, start the insertion at the tail
        if (ctl.append_start) begin
            pfx_we     = 1'b1;
            last_next  = pfx_wdata;
            count_next = count_reg + CW'(1);
            pos_next   = count_reg[IW-1:0];
        end
        // insertion: shift a larger neighbor up, or drop the value in
        if (ctl.ins_step) begin
            srt_we = 1'b1;
            if (flags.ins_done) begin
                srt_wdata = value_reg;
            end else begin
                pos_next = pos_reg - IW'(1);
            end
        end
        if (ctl.range_finish) begin
            res_sum_next = sum_sat;
        end
        if (ctl.pair_start) begin
            a_next = '0;
            b_next = count_m1[IW-1:0];
        end
        // two-pointer step
        if (ctl.pair_step) begin
            if (flags.pair_hit) begin
                res_lo_next = FW'(rd_a);
                res_hi_next = FW'(rd_b);
            end else begin
                a_next = step_a;
                b_next = step_b;
                if (flags.pair_end) begin
                    res_status_next = rsps_pkg::ST_NO_PAIR;
                end
            end
        end
    end

    // Sorted-store read addresses follow the next pointer values; prefix reads follow the range inputs
    assign pfx_raddr0 = l_m1[IW-1:0];
    assign pfx_raddr1 = r_q[IW-1:0];
    assign srt_raddr0 = (ctl.append_start || ctl.ins_step) ? pos_next - IW'(1) : a_next;
    assign srt_raddr1 = b_next;

    // Element count and running prefix sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            last_reg  <= '0;
        end else begin
            count_reg <= count_next;
            last_reg  <= last_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        res_status_reg <= res_status_next;
        res_sum_reg    <= res_sum_next;
        res_lo_reg     <= res_lo_next;
        res_hi_reg     <= res_hi_next;
        if (ctl.capture) begin
            value_reg  <= in_elem;
            target_reg <= s_target;
            lzero_reg  <= (s_range_left == '0);
        end
        if (ctl.out_load) begin
            out_status_reg <= res_status_reg;
            out_sum_reg    <= res_sum_reg;
            out_lo_reg     <= res_lo_reg;
            out_hi_reg     <= res_hi_reg;
        end
    end

    assign m_status    = out_status_reg;
    assign m_range_sum = out_sum_reg;
    assign m_pair_low  = out_lo_reg;
    assign m_pair_high = out_hi_reg;

    // Prefix store: entry i holds the sum of the first i+1 elements
    rsps_ram #(
        .WIDTH (PW),
        .DEPTH (rsps_pkg::CAPACITY)
    ) u_prefix_ram (
        .aclk   (aclk),
        .we     (pfx_we),
        .waddr  (pfx_waddr),
        .wdata  (pfx_wdata),
        .raddr0 (pfx_raddr0),
        .raddr1 (pfx_raddr1),
        .rdata0 (pfx_rdata0),
        .rdata1 (pfx_rdata1)
    );

    // Sorted store, ascending
    rsps_ram #(
        .WIDTH (EW),
        .DEPTH (rsps_pkg::CAPACITY)
    ) u_sorted_ram (
        .aclk   (aclk),
        .we     (srt_we),
        .waddr  (srt_waddr),
        .wdata  (srt_wdata),
        .raddr0 (srt_raddr0),
        .raddr1 (srt_raddr1),
        .rdata0 (srt_rdata0),
        .rdata1 (srt_rdata1)
    );

endmodule

// ===== design/range_sum_and_pair_sum_search.sv =====
// ----------------------------------------------------------------------------
// range_sum_and_pair_sum_search
// Accepted beat to m_valid: clear, full append, bad range and short pair search
// go straight to the done state; a range query passes the range state; an append
// shifts one larger element per insert step, then drops the value in; a pair
// search steps the two pointers until a hit or until they meet. One beat in work:
// the next is taken the cycle after the result loads, which waits on m_ready.
// Synchronous active-low reset empties the data set and drops any result.
// ----------------------------------------------------------------------------
module range_sum_and_pair_sum_search (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [rsps_pkg::CMD_W-1:0]              s_command,
    input  logic signed [rsps_pkg::FIELD_W-1:0]     s_value,
    input  logic [rsps_pkg::RANGE_IDX_W-1:0]        s_range_left,
    input  logic [rsps_pkg::RANGE_IDX_W-1:0]        s_range_right,
    input  logic signed [rsps_pkg::FIELD_W-1:0]     s_target,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [rsps_pkg::STATUS_W-1:0]           m_status,
    output logic signed [rsps_pkg::RANGE_SUM_W-1:0] m_range_sum,
    output logic signed [rsps_pkg::FIELD_W-1:0]     m_pair_low,
    output logic signed [rsps_pkg::FIELD_W-1:0]     m_pair_high
);

    rsps_pkg::ctl_t   ctl;
    rsps_pkg::flags_t flags;

    // Sequencer
    rsps_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .flags     (flags),
        .ctl       (ctl)
    );

    // Stores and arithmetic
    rsps_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .flags         (flags),
        .s_value       (s_value),
        .s_range_left  (s_range_left),
        .s_range_right (s_range_right),
        .s_target      (s_target),
        .m_status      (m_status),
        .m_range_sum   (m_range_sum),
        .m_pair_low    (m_pair_low),
        .m_pair_high   (m_pair_high)
    );

endmodule
